[rtl/yuv420_pixel_pair_to_rgb_defines.svh]
// ----------------------------------------------------------------------------
// yuv420_pixel_pair_to_rgb_defines.svh
// Assertion macros used by the checker of the pixel pair converter.
// ----------------------------------------------------------------------------
`ifndef YUV420_PIXEL_PAIR_TO_RGB_DEFINES_SVH
`define YUV420_PIXEL_PAIR_TO_RGB_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define YUVP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define YUVP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/yuvp_pkg.sv]
// ----------------------------------------------------------------------------
// yuvp_pkg
// Widths, register codes, reset values and stage types of the converter.
// ----------------------------------------------------------------------------
package yuvp_pkg;

    // Field and datapath widths.
    localparam int LUMA_W     = 8;
    localparam int WEIGHT_W   = 22;
    localparam int COEF_W     = 23;
    localparam int CDIFF_W    = 9;
    localparam int YPROD_W    = 30;
    localparam int CPROD_W    = 32;
    localparam int SUM_W      = 34;
    localparam int CFG_DATA_W = 23;
    localparam int CFG_IDX_W  = 3;

    localparam int WEIGHT_SHIFT_DEF = 20;

    // Offsets of the video levels.
    localparam logic [LUMA_W-1:0]  LUMA_OFFSET   = 8'd16;
    localparam logic [CDIFF_W-1:0] CHROMA_OFFSET = 9'd128;
    localparam logic [LUMA_W-1:0]  ALPHA_OPAQUE  = 8'hFF;
    localparam logic [LUMA_W-1:0]  CHAN_MAX      = 8'd255;

    // BT.601 weights scaled by 2^20.
    localparam logic [WEIGHT_W-1:0]      LUMA_WEIGHT_RST   = 22'd1220542;
    localparam logic signed [COEF_W-1:0] RED_FROM_CR_RST   = 23'sd1673527;
    localparam logic signed [COEF_W-1:0] GREEN_FROM_CB_RST = -23'sd409993;
    localparam logic signed [COEF_W-1:0] GREEN_FROM_CR_RST = -23'sd852492;
    localparam logic signed [COEF_W-1:0] BLUE_FROM_CB_RST  = 23'sd2116026;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LUMA_WEIGHT   = 3'd0,
        REG_RED_FROM_CR   = 3'd1,
        REG_GREEN_FROM_CB = 3'd2,
        REG_GREEN_FROM_CR = 3'd3,
        REG_BLUE_FROM_CB  = 3'd4,
        REG_SWAP_CHROMA   = 3'd5,
        REG_BLUE_FIRST    = 3'd6,
        REG_ALPHA_ENABLE  = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic [WEIGHT_W-1:0]      luma_weight;
        logic signed [COEF_W-1:0] red_from_cr;
        logic signed [COEF_W-1:0] green_from_cb;
        logic signed [COEF_W-1:0] green_from_cr;
        logic signed [COEF_W-1:0] blue_from_cb;
        logic                     swap_chroma;
        logic                     blue_first;
        logic                     alpha_enable;
    } yuvp_cfg_t;

    // Stage 1: offset luma and centered chroma.
    typedef struct packed {
        logic [LUMA_W-1:0]         ly_top;
        logic [LUMA_W-1:0]         ly_bot;
        logic signed [CDIFF_W-1:0] cb;
        logic signed [CDIFF_W-1:0] cr;
    } yuvp_s1_t;

    // Stage 2: weighted terms.
    typedef struct packed {
        logic [YPROD_W-1:0]        yv_top;
        logic [YPROD_W-1:0]        yv_bot;
        logic signed [CPROD_W-1:0] rcr;
        logic signed [CPROD_W-1:0] gcb;
        logic signed [CPROD_W-1:0] gcr;
        logic signed [CPROD_W-1:0] bcb;
    } yuvp_s2_t;

    // Stage 3: rounded channel sums before scaling.
    typedef struct packed {
        logic signed [SUM_W-1:0] r_top;
        logic signed [SUM_W-1:0] g_top;
        logic signed [SUM_W-1:0] b_top;
        logic signed [SUM_W-1:0] r_bot;
        logic signed [SUM_W-1:0] g_bot;
        logic signed [SUM_W-1:0] b_bot;
    } yuvp_s3_t;

    // One output pixel, channels in output order.
    typedef struct packed {
        logic [LUMA_W-1:0] ch0;
        logic [LUMA_W-1:0] ch1;
        logic [LUMA_W-1:0] ch2;
        logic [LUMA_W-1:0] ch3;
    } yuvp_px_t;

endpackage

[rtl/yuvp_front.sv]
// ----------------------------------------------------------------------------
// yuvp_front
// First stage: luma offset with floor at zero, chroma centering and ordering.
// ----------------------------------------------------------------------------
module yuvp_front (
    input  logic                             aclk,
    input  logic                             load,
    input  logic                             swap_chroma,
    input  logic [yuvp_pkg::LUMA_W-1:0]      luma_top,
    input  logic [yuvp_pkg::LUMA_W-1:0]      luma_bottom,
    input  logic [yuvp_pkg::LUMA_W-1:0]      chroma_first,
    input  logic [yuvp_pkg::LUMA_W-1:0]      chroma_second,
    input  logic                             single_row,
    output yuvp_pkg::yuvp_s1_t               stage_o
);

    yuvp_pkg::yuvp_s1_t stage_reg;
    yuvp_pkg::yuvp_s1_t stage_next;
    logic [yuvp_pkg::CDIFF_W-1:0] c0;
    logic [yuvp_pkg::CDIFF_W-1:0] c1;
    logic [yuvp_pkg::LUMA_W-1:0]  luma_bot_sel;

    // Luma minus sixteen, floored at zero.
    function automatic logic [yuvp_pkg::LUMA_W-1:0] luma_off(
        input logic [yuvp_pkg::LUMA_W-1:0] y
    );
        return (y >= yuvp_pkg::LUMA_OFFSET) ? (y - yuvp_pkg::LUMA_OFFSET)
                                            : '0;
    endfunction

    always_comb begin
        // A lone final row repeats the top pixel.
        luma_bot_sel = single_row ? luma_top : luma_bottom;
        c0 = {1'b0, chroma_first}  - yuvp_pkg::CHROMA_OFFSET;
        c1 = {1'b0, chroma_second} - yuvp_pkg::CHROMA_OFFSET;
        stage_next.ly_top = luma_off(luma_top);
        stage_next.ly_bot = luma_off(luma_bot_sel);
        if (swap_chroma) begin
            stage_next.cr = $signed(c0);
            stage_next.cb = $signed(c1);
        end else begin
            stage_next.cb = $signed(c0);
            stage_next.cr = $signed(c1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_o = stage_reg;

endmodule

[rtl/yuvp_mult.sv]
// ----------------------------------------------------------------------------
// yuvp_mult
// Second stage: the six weight products of a pixel pair.
// ----------------------------------------------------------------------------
module yuvp_mult (
    input  logic                aclk,
    input  logic                load,
    input  yuvp_pkg::yuvp_cfg_t cfg,
    input  yuvp_pkg::yuvp_s1_t  stage_i,
    output yuvp_pkg::yuvp_s2_t  stage_o
);

    localparam int YW = yuvp_pkg::YPROD_W;
    localparam int CW = yuvp_pkg::CPROD_W;

    yuvp_pkg::yuvp_s2_t stage_reg;
    yuvp_pkg::yuvp_s2_t stage_next;

    // Luma products are unsigned; chroma products are signed by signed.
    always_comb begin
        stage_next.yv_top = YW'(cfg.luma_weight) * YW'(stage_i.ly_top);
        stage_next.yv_bot = YW'(cfg.luma_weight) * YW'(stage_i.ly_bot);
        stage_next.rcr    = CW'(cfg.red_from_cr)   * CW'(stage_i.cr);
        stage_next.gcb    = CW'(cfg.green_from_cb) * CW'(stage_i.cb);
        stage_next.gcr    = CW'(cfg.green_from_cr) * CW'(stage_i.cr);
        stage_next.bcb    = CW'(cfg.blue_from_cb)  * CW'(stage_i.cb);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_o = stage_reg;

endmodule

[rtl/yuvp_sum.sv]
// ----------------------------------------------------------------------------
// yuvp_sum
// Third stage: channel sums with the rounding half added.
// ----------------------------------------------------------------------------
module yuvp_sum #(
    parameter int WEIGHT_SHIFT = yuvp_pkg::WEIGHT_SHIFT_DEF
) (
    input  logic               aclk,
    input  logic               load,
    input  yuvp_pkg::yuvp_s2_t stage_i,
    output yuvp_pkg::yuvp_s3_t stage_o
);

    localparam int SW = yuvp_pkg::SUM_W;
    localparam logic signed [SW-1:0] ROUND = SW'(1) << (WEIGHT_SHIFT - 1);

    yuvp_pkg::yuvp_s3_t stage_reg;
    yuvp_pkg::yuvp_s3_t stage_next;
    logic signed [SW-1:0] y_top;
    logic signed [SW-1:0] y_bot;
    logic signed [SW-1:0] rc;
    logic signed [SW-1:0] gc;
    logic signed [SW-1:0] bc;

    always_comb begin
        // Widen the terms; the chroma part is shared by both pixels.
        y_top = SW'($signed({1'b0, stage_i.yv_top}));
        y_bot = SW'($signed({1'b0, stage_i.yv_bot}));
        rc = SW'(stage_i.rcr) + ROUND;
        gc = SW'(stage_i.gcb) + SW'(stage_i.gcr) + ROUND;
        bc = SW'(stage_i.bcb) + ROUND;
        stage_next.r_top = y_top + rc;
        stage_next.g_top = y_top + gc;
        stage_next.b_top = y_top + bc;
        stage_next.r_bot = y_bot + rc;
        stage_next.g_bot = y_bot + gc;
        stage_next.b_bot = y_bot + bc;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_o = stage_reg;

endmodule

[rtl/yuvp_out.sv]
// ----------------------------------------------------------------------------
// yuvp_out
// Last stage: scaling shift, clamp to 0..255, channel order and alpha.
// ----------------------------------------------------------------------------
module yuvp_out #(
    parameter int WEIGHT_SHIFT = yuvp_pkg::WEIGHT_SHIFT_DEF
) (
    input  logic                aclk,
    input  logic                load,
    input  yuvp_pkg::yuvp_cfg_t cfg,
    input  yuvp_pkg::yuvp_s3_t  stage_i,
    output yuvp_pkg::yuvp_px_t  top_o,
    output yuvp_pkg::yuvp_px_t  bot_o
);

    localparam int SW = yuvp_pkg::SUM_W;
    localparam int LW = yuvp_pkg::LUMA_W;

    yuvp_pkg::yuvp_px_t top_reg;
    yuvp_pkg::yuvp_px_t top_next;
    yuvp_pkg::yuvp_px_t bot_reg;
    yuvp_pkg::yuvp_px_t bot_next;

    // Floor shift, then saturate to one byte.
    function automatic logic [LW-1:0] finish(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] q;
        q = s >>> WEIGHT_SHIFT;
        if (q[SW-1]) begin
            return '0;
        end else if (|q[SW-2:LW]) begin
            return yuvp_pkg::CHAN_MAX;
        end else begin
            return q[LW-1:0];
        end
    endfunction

    // Build one pixel in the selected channel order.
    function automatic yuvp_pkg::yuvp_px_t pack(
        input logic signed [SW-1:0] r,
        input logic signed [SW-1:0] g,
        input logic signed [SW-1:0] b,
        input logic                 blue_first,
        input logic                 alpha_enable
    );
        yuvp_pkg::yuvp_px_t px;
        px.ch0 = blue_first ? finish(b) : finish(r);
        px.ch1 = finish(g);
        px.ch2 = blue_first ? finish(r) : finish(b);
        px.ch3 = alpha_enable ? yuvp_pkg::ALPHA_OPAQUE : '0;
        return px;
    endfunction

    always_comb begin
        top_next = pack(stage_i.r_top, stage_i.g_top, stage_i.b_top,
                        cfg.blue_first, cfg.alpha_enable);
        bot_next = pack(stage_i.r_bot, stage_i.g_bot, stage_i.b_bot,
                        cfg.blue_first, cfg.alpha_enable);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            top_reg <= top_next;
            bot_reg <= bot_next;
        end
    end

    assign top_o = top_reg;
    assign bot_o = bot_reg;

endmodule

[rtl/yuv420_pixel_pair_to_rgb.sv]
// ----------------------------------------------------------------------------
// yuv420_pixel_pair_to_rgb
// Throughput: one pixel pair per cycle, set by the four-stage register
// pipeline (prepare, multiply, sum, clamp); a stall holds each full stage
// whose successor is blocked, while empty stages still fill.
// Reset: synchronous active-low aresetn empties the pipeline and loads the
// BT.601 weights; swap, blue-first and alpha settings come out of reset off.
// ----------------------------------------------------------------------------
module yuv420_pixel_pair_to_rgb #(
    parameter int WEIGHT_SHIFT = yuvp_pkg::WEIGHT_SHIFT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [yuvp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [yuvp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input items.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [yuvp_pkg::LUMA_W-1:0]         s_luma_top,
    input  logic [yuvp_pkg::LUMA_W-1:0]         s_luma_bottom,
    input  logic [yuvp_pkg::LUMA_W-1:0]         s_chroma_first,
    input  logic [yuvp_pkg::LUMA_W-1:0]         s_chroma_second,
    input  logic                                s_single_row,
    // Result items.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [yuvp_pkg::LUMA_W-1:0]         m_top_ch0,
    output logic [yuvp_pkg::LUMA_W-1:0]         m_top_ch1,
    output logic [yuvp_pkg::LUMA_W-1:0]         m_top_ch2,
    output logic [yuvp_pkg::LUMA_W-1:0]         m_top_ch3,
    output logic [yuvp_pkg::LUMA_W-1:0]         m_bottom_ch0,
    output logic [yuvp_pkg::LUMA_W-1:0]         m_bottom_ch1,
    output logic [yuvp_pkg::LUMA_W-1:0]         m_bottom_ch2,
    output logic [yuvp_pkg::LUMA_W-1:0]         m_bottom_ch3
);

    localparam int NSTAGE = 4;

    yuvp_pkg::yuvp_cfg_t cfg_reg;
    yuvp_pkg::yuvp_cfg_t cfg_next;
    logic [NSTAGE-1:0]   valid_reg;
    logic [NSTAGE-1:0]   valid_next;
    logic [NSTAGE-1:0]   stage_rdy;
    logic [NSTAGE-1:0]   stage_load;

    yuvp_pkg::yuvp_s1_t s1;
    yuvp_pkg::yuvp_s2_t s2;
    yuvp_pkg::yuvp_s3_t s3;
    yuvp_pkg::yuvp_px_t px_top;
    yuvp_pkg::yuvp_px_t px_bot;

    // Configuration register file.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (yuvp_pkg::cfg_reg_e'(cfg_index))
                yuvp_pkg::REG_LUMA_WEIGHT:
                    cfg_next.luma_weight = cfg_wdata[yuvp_pkg::WEIGHT_W-1:0];
                yuvp_pkg::REG_RED_FROM_CR:   cfg_next.red_from_cr   = $signed(cfg_wdata);
                yuvp_pkg::REG_GREEN_FROM_CB: cfg_next.green_from_cb = $signed(cfg_wdata);
                yuvp_pkg::REG_GREEN_FROM_CR: cfg_next.green_from_cr = $signed(cfg_wdata);
                yuvp_pkg::REG_BLUE_FROM_CB:  cfg_next.blue_from_cb  = $signed(cfg_wdata);
                yuvp_pkg::REG_SWAP_CHROMA:   cfg_next.swap_chroma   = cfg_wdata[0];
                yuvp_pkg::REG_BLUE_FIRST:    cfg_next.blue_first    = cfg_wdata[0];
                yuvp_pkg::REG_ALPHA_ENABLE:  cfg_next.alpha_enable  = cfg_wdata[0];
            endcase
        end
    end

    // A stage takes new data when it is empty or its contents move on.
    always_comb begin
        stage_rdy[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];
        end
        valid_next    = valid_reg;
        stage_load[0] = stage_rdy[0] && s_valid;
        if (stage_rdy[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i < NSTAGE; i++) begin
            stage_load[i] = stage_rdy[i] && valid_reg[i-1];
            if (stage_rdy[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            cfg_reg.luma_weight   <= yuvp_pkg::LUMA_WEIGHT_RST;
            cfg_reg.red_from_cr   <= yuvp_pkg::RED_FROM_CR_RST;
            cfg_reg.green_from_cb <= yuvp_pkg::GREEN_FROM_CB_RST;
            cfg_reg.green_from_cr <= yuvp_pkg::GREEN_FROM_CR_RST;
            cfg_reg.blue_from_cb  <= yuvp_pkg::BLUE_FROM_CB_RST;
            cfg_reg.swap_chroma   <= 1'b0;
            cfg_reg.blue_first    <= 1'b0;
            cfg_reg.alpha_enable  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            cfg_reg   <= cfg_next;
        end
    end

    yuvp_front u_front (
        .aclk          (aclk),
        .load          (stage_load[0]),
        .swap_chroma   (cfg_reg.swap_chroma),
        .luma_top      (s_luma_top),
        .luma_bottom   (s_luma_bottom),
        .chroma_first  (s_chroma_first),
        .chroma_second (s_chroma_second),
        .single_row    (s_single_row),
        .stage_o       (s1)
    );

    yuvp_mult u_mult (
        .aclk    (aclk),
        .load    (stage_load[1]),
        .cfg     (cfg_reg),
        .stage_i (s1),
        .stage_o (s2)
    );

    yuvp_sum #(
        .WEIGHT_SHIFT (WEIGHT_SHIFT)
    ) u_sum (
        .aclk    (aclk),
        .load    (stage_load[2]),
        .stage_i (s2),
        .stage_o (s3)
    );

    yuvp_out #(
        .WEIGHT_SHIFT (WEIGHT_SHIFT)
    ) u_out (
        .aclk    (aclk),
        .load    (stage_load[3]),
        .cfg     (cfg_reg),
        .stage_i (s3),
        .top_o   (px_top),
        .bot_o   (px_bot)
    );

    assign s_ready      = stage_rdy[0];
    assign m_valid      = valid_reg[NSTAGE-1];
    assign m_top_ch0    = px_top.ch0;
    assign m_top_ch1    = px_top.ch1;
    assign m_top_ch2    = px_top.ch2;
    assign m_top_ch3    = px_top.ch3;
    assign m_bottom_ch0 = px_bot.ch0;
    assign m_bottom_ch1 = px_bot.ch1;
    assign m_bottom_ch2 = px_bot.ch2;
    assign m_bottom_ch3 = px_bot.ch3;

endmodule

[rtl/yuvp_checker.sv]
// ----------------------------------------------------------------------------
// yuvp_checker
// Port-level checks of the pixel pair converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "yuv420_pixel_pair_to_rgb_defines.svh"

module yuvp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [yuvp_pkg::LUMA_W-1:0]     m_top_ch0,
    input logic [yuvp_pkg::LUMA_W-1:0]     m_top_ch1,
    input logic [yuvp_pkg::LUMA_W-1:0]     m_top_ch2,
    input logic [yuvp_pkg::LUMA_W-1:0]     m_top_ch3,
    input logic [yuvp_pkg::LUMA_W-1:0]     m_bottom_ch0,
    input logic [yuvp_pkg::LUMA_W-1:0]     m_bottom_ch1,
    input logic [yuvp_pkg::LUMA_W-1:0]     m_bottom_ch2,
    input logic [yuvp_pkg::LUMA_W-1:0]     m_bottom_ch3
);

    // A stalled result stays offered.
    `YUVP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "result dropped while stalled")

    // A stalled result keeps its colour channel values.
    `YUVP_ASSERT_NEXT(a_out_stable, m_valid && !m_ready, $stable(m_top_ch0) && $stable(m_top_ch1) && $stable(m_top_ch2) && $stable(m_bottom_ch0) && $stable(m_bottom_ch1) && $stable(m_bottom_ch2), "stalled result changed")

    // With the output stage empty, nothing can back-pressure the input.
    `YUVP_ASSERT_NOW(a_in_free, !m_valid, s_ready, "input stalled with empty output")

    // Alpha is one setting for both pixels: fully opaque or zero.
    `YUVP_ASSERT_NOW(a_alpha, m_valid, (m_top_ch3 == m_bottom_ch3) && (m_top_ch3 == 8'h00 || m_top_ch3 == 8'hFF), "bad alpha byte")

endmodule

bind yuv420_pixel_pair_to_rgb yuvp_checker u_yuvp_checker (.*);
